// ===== hw/rtl/twkm_pkg.sv =====
package twkm_pkg;

  // Default table sizes
  localparam int unsigned KERN_DEPTH_DEF  = 64;
  localparam int unsigned GLYPH_CODES_DEF = 256;

  // Multiplier operand and product widths
  localparam int unsigned FACTOR_W = 14;
  localparam int unsigned PROD_W   = 31;

  // Request command codes
  localparam logic [1:0] CMD_LOAD_GLYPH = 2'd0;
  localparam logic [1:0] CMD_LOAD_KERN  = 2'd1;
  localparam logic [1:0] CMD_MEASURE    = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCALE     = 2'd0,
    CFG_PAD_LEFT  = 2'd1,
    CFG_PAD_RIGHT = 2'd2,
    CFG_SPACING_X = 2'd3
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ACC
  } state_e;

  // Glyph memory entry
  typedef struct packed {
    logic               valid;
    logic signed [11:0] advance;
  } glyph_ent_t;

  // Kerning memory entry
  typedef struct packed {
    logic               valid;
    logic [7:0]         lead_code;
    logic [7:0]         after;
    logic signed [11:0] amount;
  } kern_ent_t;

  // Controls from the sequencer to the accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic last;
    logic missing;
  } acc_ctl_t;

endpackage

// ===== hw/rtl/text_width_kerning_measure.sv =====
// Text width measurement with kerning.
// Requests enter on start_i while busy_o is low, with command_i selecting a
// glyph advance load, a kerning entry load or a measured character. Loads are
// written at the accept edge and produce no result. A measured character
// produces one result: running_width_o, is_last_o and glyph_missing_o are
// valid for exactly one cycle while done_o is high; the receiver cannot stall.
// A measure request passes through the scan, multiply and accumulate states
// before done_o. The kerning scan reads one entry per cycle from the single
// read port of the kerning memory and stops at the first matching entry or
// the last entry, then the multiply and accumulate states follow. A load
// request leaves the block idle. Requests are handled one at a time; the
// next request is taken in the cycle done_o is high.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// write edge and are accepted at any time, including during the clearing pass.
// After reset the block runs a clearing pass over both memories, holding
// busy_o high; registers return to their reset values and the running width
// and previous code start at zero.
module text_width_kerning_measure #(
  parameter int unsigned KERN_DEPTH  = twkm_pkg::KERN_DEPTH_DEF,
  parameter int unsigned GLYPH_CODES = twkm_pkg::GLYPH_CODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic [7:0]         char_code_i,
  input  logic [7:0]         before_code_i,
  input  logic [5:0]         entry_slot_i,
  input  logic signed [11:0] amount_i,
  input  logic               end_of_text_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic signed [31:0] running_width_o,
  output logic               is_last_o,
  output logic               glyph_missing_o,
  output logic               done_o
);

  localparam int unsigned KAW   = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
  localparam int unsigned GAW   = $clog2(GLYPH_CODES);
  localparam int unsigned CLR_N = (KERN_DEPTH > GLYPH_CODES) ? KERN_DEPTH : GLYPH_CODES;
  localparam int unsigned CAW   = $clog2(CLR_N);
  localparam int unsigned KEW   = $bits(twkm_pkg::kern_ent_t);
  localparam int unsigned GEW   = $bits(twkm_pkg::glyph_ent_t);

  twkm_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [15:0]       scale_q;
  logic [7:0]        pad_left_q;
  logic [7:0]        pad_right_q;
  logic signed [7:0] spacing_x_q;

  // Sequencer registers
  logic [CAW-1:0]     clr_q;
  logic [KAW-1:0]     scan_q;
  logic [7:0]         code_q;
  logic [7:0]         prev_q;
  logic               last_q;
  logic               in_range_q;
  logic signed [11:0] kern_q;

  // Memory ports
  logic                  kern_we, kern_re, glyph_we, glyph_re;
  logic [KAW-1:0]        kern_waddr, kern_raddr;
  logic [GAW-1:0]        glyph_waddr;
  twkm_pkg::kern_ent_t   kern_wdata, kern_rd;
  twkm_pkg::glyph_ent_t  glyph_wdata, glyph_rd;
  logic [KEW-1:0]        kern_rdata;
  logic [GEW-1:0]        glyph_rdata;

  logic                              accept;
  logic                              is_measure;
  logic                              slot_ok;
  logic                              code_ok;
  logic                              kern_hit;
  logic                              scan_end;
  logic                              missing;
  logic signed [twkm_pkg::FACTOR_W-1:0] adv;
  logic signed [twkm_pkg::FACTOR_W-1:0] factor;
  twkm_pkg::acc_ctl_t                acc_ctl;

  assign busy_o     = (state_q != twkm_pkg::ST_IDLE);
  assign accept     = start_i && !busy_o;
  assign is_measure = (command_i == twkm_pkg::CMD_MEASURE);
  assign slot_ok    = (32'(entry_slot_i) < KERN_DEPTH);
  assign code_ok    = (32'(char_code_i) < GLYPH_CODES);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= 16'd256;
      pad_left_q  <= '0;
      pad_right_q <= '0;
      spacing_x_q <= '0;
    end else if (cfg_we_i) begin
      unique case (twkm_pkg::cfg_idx_e'(cfg_idx_i))
        twkm_pkg::CFG_SCALE:     scale_q     <= cfg_wdata_i;
        twkm_pkg::CFG_PAD_LEFT:  pad_left_q  <= cfg_wdata_i[7:0];
        twkm_pkg::CFG_PAD_RIGHT: pad_right_q <= cfg_wdata_i[7:0];
        twkm_pkg::CFG_SPACING_X: spacing_x_q <= $signed(cfg_wdata_i[7:0]);
      endcase
    end
  end

  // Kerning match on the entry read last cycle
  assign kern_rd  = twkm_pkg::kern_ent_t'(kern_rdata);
  assign glyph_rd = twkm_pkg::glyph_ent_t'(glyph_rdata);
  assign kern_hit = kern_rd.valid && (kern_rd.lead_code == prev_q) && (kern_rd.after == code_q);
  assign scan_end = kern_hit || (scan_q == KAW'(KERN_DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twkm_pkg::ST_CLEAR: if (clr_q == CAW'(CLR_N - 1)) state_d = twkm_pkg::ST_IDLE;
      twkm_pkg::ST_IDLE:  if (accept && is_measure) state_d = twkm_pkg::ST_SCAN;
      twkm_pkg::ST_SCAN:  if (scan_end) state_d = twkm_pkg::ST_MUL;
      twkm_pkg::ST_MUL:   state_d = twkm_pkg::ST_ACC;
      twkm_pkg::ST_ACC:   state_d = twkm_pkg::ST_IDLE;
      default:            state_d = twkm_pkg::ST_IDLE;
    endcase
  end

  // Memory and accumulate controls
  always_comb begin
    kern_we     = 1'b0;
    kern_waddr  = KAW'(entry_slot_i);
    kern_wdata  = '{valid: 1'b1, lead_code: before_code_i, after: char_code_i,
                    amount: amount_i};
    kern_re     = 1'b0;
    kern_raddr  = '0;
    glyph_we    = 1'b0;
    glyph_waddr = GAW'(char_code_i);
    glyph_wdata = '{valid: 1'b1, advance: amount_i};
    glyph_re    = 1'b0;
    acc_ctl     = '{mul_en: 1'b0, acc_en: 1'b0, last: last_q, missing: missing};
    unique case (state_q)
      twkm_pkg::ST_CLEAR: begin
        kern_we     = (32'(clr_q) < KERN_DEPTH);
        kern_waddr  = KAW'(clr_q);
        kern_wdata  = '0;
        glyph_we    = (32'(clr_q) < GLYPH_CODES);
        glyph_waddr = GAW'(clr_q);
        glyph_wdata = '0;
      end
      twkm_pkg::ST_IDLE: begin
        if (accept) begin
          case (command_i)
            twkm_pkg::CMD_LOAD_GLYPH: glyph_we = code_ok;
            twkm_pkg::CMD_LOAD_KERN:  kern_we  = slot_ok;
            twkm_pkg::CMD_MEASURE: begin
              kern_re  = 1'b1;
              glyph_re = code_ok;
            end
            default: ;
          endcase
        end
      end
      twkm_pkg::ST_SCAN: begin
        kern_re    = 1'b1;
        kern_raddr = scan_q + KAW'(1);
      end
      twkm_pkg::ST_MUL: acc_ctl.mul_en = 1'b1;
      twkm_pkg::ST_ACC: acc_ctl.acc_en = 1'b1;
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twkm_pkg::ST_CLEAR;
      clr_q   <= '0;
      scan_q  <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == twkm_pkg::ST_CLEAR) begin
        clr_q <= clr_q + CAW'(1);
      end
      if (accept && is_measure) begin
        scan_q <= '0;
      end else if (state_q == twkm_pkg::ST_SCAN && !scan_end) begin
        scan_q <= scan_q + KAW'(1);
      end
      if (state_q == twkm_pkg::ST_ACC) begin
        prev_q <= last_q ? 8'd0 : code_q;
      end
    end
  end

  // Request payload and kerning term
  always_ff @(posedge clk_i) begin
    if (accept && is_measure) begin
      code_q     <= char_code_i;
      last_q     <= end_of_text_i;
      in_range_q <= code_ok;
    end
    if (state_q == twkm_pkg::ST_SCAN && scan_end) begin
      kern_q <= kern_hit ? kern_rd.amount : 12'sd0;
    end
  end

  // Advance less padding and spacing, plus kerning
  assign missing = !(in_range_q && glyph_rd.valid);
  assign adv     = {{2{glyph_rd.advance[11]}}, glyph_rd.advance}
                 - $signed({6'd0, pad_left_q})
                 - $signed({6'd0, pad_right_q})
                 - {{6{spacing_x_q[7]}}, spacing_x_q};
  assign factor  = (missing ? '0 : adv) + {{2{kern_q[11]}}, kern_q};

  twkm_ram #(
    .DEPTH (KERN_DEPTH),
    .WIDTH (KEW)
  ) u_kern_ram (
    .clk_i   (clk_i),
    .we_i    (kern_we),
    .waddr_i (kern_waddr),
    .wdata_i (kern_wdata),
    .re_i    (kern_re),
    .raddr_i (kern_raddr),
    .rdata_o (kern_rdata)
  );

  twkm_ram #(
    .DEPTH (GLYPH_CODES),
    .WIDTH (GEW)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (glyph_waddr),
    .wdata_i (glyph_wdata),
    .re_i    (glyph_re),
    .raddr_i (GAW'(char_code_i)),
    .rdata_o (glyph_rdata)
  );

  twkm_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (acc_ctl),
    .factor_i        (factor),
    .scale_i         (scale_q),
    .running_width_o (running_width_o),
    .is_last_o       (is_last_o),
    .glyph_missing_o (glyph_missing_o),
    .done_o          (done_o)
  );

`ifndef NO_ASSERTIONS
  // A result appears only right after the accumulate cycle
  a_done_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == twkm_pkg::ST_ACC) && (state_q == twkm_pkg::ST_IDLE))
    else $error("result strobe outside accumulate");

  // A measure request starts the kerning scan
  a_measure_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_measure) |=> (state_q == twkm_pkg::ST_SCAN) && (scan_q == '0))
    else $error("measure did not start scan");

  // Loads and ignored commands leave the block idle and produce no result
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_measure) |=> (state_q == twkm_pkg::ST_IDLE) && !done_o)
    else $error("load left the block busy");

  // Scan index stays inside the kerning table
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twkm_pkg::ST_SCAN) |-> (32'(scan_q) < KERN_DEPTH))
    else $error("scan index out of range");
`endif

endmodule

// ===== hw/rtl/twkm_ram.sv =====
module twkm_ram #(
  parameter int unsigned DEPTH = twkm_pkg::KERN_DEPTH_DEF,
  parameter int unsigned WIDTH = $bits(twkm_pkg::kern_ent_t)
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/twkm_accum.sv =====
module twkm_accum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  twkm_pkg::acc_ctl_t                   ctl_i,
  input  logic signed [twkm_pkg::FACTOR_W-1:0] factor_i,
  input  logic [15:0]                          scale_i,
  output logic signed [31:0]                   running_width_o,
  output logic                                 is_last_o,
  output logic                                 glyph_missing_o,
  output logic                                 done_o
);

  logic signed [twkm_pkg::PROD_W-1:0] prod_q;
  logic signed [31:0]                 acc_q;
  logic signed [31:0]                 width_q;
  logic                               last_q;
  logic                               missing_q;
  logic                               done_q;
  logic signed [32:0]                 sum;
  logic signed [31:0]                 sat;
  logic signed [16:0]                 scale_s;

  assign scale_s = $signed({1'b0, scale_i});

  // Product stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= factor_i * scale_s;
    end
  end

  // Add and saturate to the signed 32-bit range
  always_comb begin
    sum = $signed({acc_q[31], acc_q})
        + $signed({{(33 - twkm_pkg::PROD_W){prod_q[twkm_pkg::PROD_W-1]}}, prod_q});
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat = sum[31:0];
    end
  end

  // Accumulator, cleared after the last character of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.acc_en;
      if (ctl_i.acc_en) begin
        acc_q <= ctl_i.last ? 32'sd0 : sat;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_en) begin
      width_q   <= sat;
      last_q    <= ctl_i.last;
      missing_q <= ctl_i.missing;
    end
  end

  assign running_width_o = width_q;
  assign is_last_o       = last_q;
  assign glyph_missing_o = missing_q;
  assign done_o          = done_q;

endmodule

// ===== bench/text_width_kerning_measure_tb.sv =====
module text_width_kerning_measure_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Reserved command code, the block must ignore it
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DIR_N = 20;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         code;
    logic [7:0]         lead;
    logic [5:0]         slot;
    logic signed [11:0] amount;
    logic               eot;
  } text_req_t;

  typedef struct packed {
    logic signed [31:0] width;
    logic               last;
    logic               missing;
  } width_res_t;

  typedef struct packed {
    text_req_t  req;
    logic       chk;
    width_res_t res;
  } dir_row_t;

  // Directed requests; rows with chk set carry a hand-computed result at scale 1.0
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // nothing loaded yet: missing glyph, zero width
    '{'{twkm_pkg::CMD_MEASURE, 8'h00, 8'h00, 6'd0, 12'sd0, 1'b0}, 1'b1,
      '{32'sd0, 1'b0, 1'b1}},
    '{'{twkm_pkg::CMD_MEASURE, 8'hFF, 8'hFF, 6'd63, 12'sd2047, 1'b1}, 1'b1,
      '{32'sd0, 1'b1, 1'b1}},
    // glyph table, advance extremes
    '{'{twkm_pkg::CMD_LOAD_GLYPH, 8'h00, 8'hFF, 6'd63, 12'sd2047, 1'b1}, 1'b0, '0},
    '{'{twkm_pkg::CMD_LOAD_GLYPH, 8'hFF, 8'h00, 6'd0, -12'sd2048, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_LOAD_GLYPH, 8'h41, 8'h00, 6'd0, 12'sd10, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_LOAD_GLYPH, 8'h42, 8'h00, 6'd0, 12'sd7, 1'b0}, 1'b0, '0},
    // kerning: slot 1 is shadowed by slot 0, slot 63 matches a first character
    '{'{twkm_pkg::CMD_LOAD_KERN, 8'h42, 8'h41, 6'd0, -12'sd3, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_LOAD_KERN, 8'h41, 8'h00, 6'd63, 12'sd2047, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_LOAD_KERN, 8'h42, 8'h41, 6'd1, 12'sd100, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_MEASURE, 8'h41, 8'h00, 6'd0, 12'sd0, 1'b0}, 1'b1,
      '{32'sd526592, 1'b0, 1'b0}},
    '{'{twkm_pkg::CMD_MEASURE, 8'h42, 8'h00, 6'd0, 12'sd0, 1'b0}, 1'b1,
      '{32'sd527616, 1'b0, 1'b0}},
    '{'{twkm_pkg::CMD_MEASURE, 8'h00, 8'h00, 6'd0, 12'sd0, 1'b0}, 1'b1,
      '{32'sd1051648, 1'b0, 1'b0}},
    '{'{twkm_pkg::CMD_MEASURE, 8'hFF, 8'h00, 6'd0, 12'sd0, 1'b1}, 1'b1,
      '{32'sd527360, 1'b1, 1'b0}},
    // reloads overwrite; slot 1 now wins for 0x41 -> 0x42
    '{'{twkm_pkg::CMD_LOAD_GLYPH, 8'h41, 8'h00, 6'd0, -12'sd1, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_LOAD_KERN, 8'h55, 8'hAA, 6'd0, -12'sd2048, 1'b0}, 1'b0, '0},
    '{'{CMD_RESERVED, 8'h41, 8'h00, 6'd2, 12'sd2047, 1'b1}, 1'b0, '0},
    '{'{twkm_pkg::CMD_MEASURE, 8'h41, 8'h00, 6'd0, 12'sd0, 1'b0}, 1'b1,
      '{32'sd523776, 1'b0, 1'b0}},
    '{'{twkm_pkg::CMD_MEASURE, 8'h42, 8'h00, 6'd0, 12'sd0, 1'b1}, 1'b1,
      '{32'sd551168, 1'b1, 1'b0}},
    // kerning still applies to a missing glyph
    '{'{twkm_pkg::CMD_LOAD_KERN, 8'h80, 8'h00, 6'd2, 12'sd5, 1'b0}, 1'b0, '0},
    '{'{twkm_pkg::CMD_MEASURE, 8'h80, 8'h00, 6'd0, 12'sd0, 1'b1}, 1'b1,
      '{32'sd1280, 1'b1, 1'b1}}
  };

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         command_i = twkm_pkg::CMD_LOAD_GLYPH;
  logic [7:0]         char_code_i = '0;
  logic [7:0]         before_code_i = '0;
  logic [5:0]         entry_slot_i = '0;
  logic signed [11:0] amount_i = '0;
  logic               end_of_text_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = twkm_pkg::CFG_SCALE;
  logic [15:0]        cfg_wdata_i = '0;
  logic signed [31:0] running_width_o;
  logic               is_last_o;
  logic               glyph_missing_o;
  logic               done_o;

  // Shadow copy of the block's tables, text state and registers
  logic signed [11:0] glyph_adv_m [twkm_pkg::GLYPH_CODES_DEF];
  bit                 glyph_vld_m [twkm_pkg::GLYPH_CODES_DEF];
  logic [7:0]         kern_bef_m [twkm_pkg::KERN_DEPTH_DEF];
  logic [7:0]         kern_aft_m [twkm_pkg::KERN_DEPTH_DEF];
  logic signed [11:0] kern_amt_m [twkm_pkg::KERN_DEPTH_DEF];
  bit                 kern_vld_m [twkm_pkg::KERN_DEPTH_DEF];
  logic [7:0]         prev_code_m = '0;
  longint             width_acc_m = 0;
  logic [15:0]        scale_r = 16'd256;
  logic [7:0]         pad_l_r = '0;
  logic [7:0]         pad_r_r = '0;
  logic signed [7:0]  spacing_r = '0;

  width_res_t width_expect_q [$];
  int                 mismatch_cnt = 0;

  text_width_kerning_measure dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .before_code_i   (before_code_i),
    .entry_slot_i    (entry_slot_i),
    .amount_i        (amount_i),
    .end_of_text_i   (end_of_text_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .running_width_o (running_width_o),
    .is_last_o       (is_last_o),
    .glyph_missing_o (glyph_missing_o),
    .done_o          (done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow state; returns 1 when a width comes out
  function automatic bit predict_width(input text_req_t r, output width_res_t res);
    longint delta;
    longint sum;
    bit     miss;
    bit     hit;
    int     i;
    res = '0;
    case (r.cmd)
      twkm_pkg::CMD_LOAD_GLYPH: begin
        glyph_adv_m[r.code] = r.amount;
        glyph_vld_m[r.code] = 1'b1;
        return 1'b0;
      end
      twkm_pkg::CMD_LOAD_KERN: begin
        kern_bef_m[r.slot] = r.lead;
        kern_aft_m[r.slot] = r.code;
        kern_amt_m[r.slot] = r.amount;
        kern_vld_m[r.slot] = 1'b1;
        return 1'b0;
      end
      twkm_pkg::CMD_MEASURE: ;
      default: return 1'b0;
    endcase
    delta = 0;
    hit = 1'b0;
    // first matching pair in slot order
    for (i = 0; i < twkm_pkg::KERN_DEPTH_DEF; i++) begin
      if (!hit && kern_vld_m[i] && kern_bef_m[i] == prev_code_m
          && kern_aft_m[i] == r.code) begin
        delta = longint'(kern_amt_m[i]) * longint'(scale_r);
        hit = 1'b1;
      end
    end
    miss = !glyph_vld_m[r.code];
    if (!miss) begin
      delta += (longint'(glyph_adv_m[r.code]) - longint'(pad_l_r) - longint'(pad_r_r)
                - longint'(spacing_r)) * longint'(scale_r);
    end
    sum = width_acc_m + delta;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    width_acc_m = sum;
    res.width = sum[31:0];
    res.last = r.eot;
    res.missing = miss;
    if (r.eot) begin
      width_acc_m = 0;
      prev_code_m = '0;
    end else begin
      prev_code_m = r.code;
    end
    return 1'b1;
  endfunction

  // Drives one request, holds it until accepted, records what it should produce
  task automatic issue(input text_req_t r, input bit typed, input width_res_t typed_res);
    width_res_t res;
    start_i <= 1'b1;
    command_i <= r.cmd;
    char_code_i <= r.code;
    before_code_i <= r.lead;
    entry_slot_i <= r.slot;
    amount_i <= r.amount;
    end_of_text_i <= r.eot;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (predict_width(r, res)) width_expect_q.push_back(typed ? typed_res : res);
  endtask

  // Stimulus: directed table, then randomized phases under changing settings
  initial begin
    text_req_t   r;
    logic [15:0] cfg_vals [4];
    logic [7:0]  alpha [8];
    int          amt_lo;
    int          amt_hi;
    int          eot_one_in;
    int          amt;
    int          gap;
    int          burst;
    int          counted;
    int          sel;
    int          ph;
    int          k;
    int          b;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < DIR_N; k++) begin
      issue(DIR_ROWS[k].req, DIR_ROWS[k].chk, DIR_ROWS[k].res);
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      // settle: results drained, no scan still running
      while (width_expect_q.size() != 0) @(posedge clk_i);
      repeat (twkm_pkg::KERN_DEPTH_DEF + 6) @(posedge clk_i);
      while (busy_o !== 1'b0) @(posedge clk_i);

      amt_lo = -2048;
      amt_hi = 2047;
      eot_one_in = 6;
      case (ph)
        0: begin
          // push toward positive saturation
          cfg_vals[twkm_pkg::CFG_SCALE] = 16'hFFFF;
          cfg_vals[twkm_pkg::CFG_PAD_LEFT] = 16'h0000;
          cfg_vals[twkm_pkg::CFG_PAD_RIGHT] = 16'h0000;
          cfg_vals[twkm_pkg::CFG_SPACING_X] = 16'h0080;
          amt_lo = 1024;
          eot_one_in = 60;
        end
        1: begin
          // push toward negative saturation
          cfg_vals[twkm_pkg::CFG_SCALE] = 16'hFFFF;
          cfg_vals[twkm_pkg::CFG_PAD_LEFT] = 16'hFFFF;
          cfg_vals[twkm_pkg::CFG_PAD_RIGHT] = 16'hA5FF;
          cfg_vals[twkm_pkg::CFG_SPACING_X] = 16'h5A7F;
          amt_hi = -1024;
          eot_one_in = 60;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: cfg_vals[twkm_pkg::CFG_SCALE] = (ph == 2) ? 16'h0000 : 16'h0001;
            1: cfg_vals[twkm_pkg::CFG_SCALE] = 16'd256;
            2: cfg_vals[twkm_pkg::CFG_SCALE] = 16'hFFFF;
            default: cfg_vals[twkm_pkg::CFG_SCALE] = 16'($urandom);
          endcase
          if (ph == 2) cfg_vals[twkm_pkg::CFG_SCALE] = 16'h0000;
          cfg_vals[twkm_pkg::CFG_PAD_LEFT] =
            {8'($urandom), ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom)};
          cfg_vals[twkm_pkg::CFG_PAD_RIGHT] =
            {8'($urandom), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom)};
          cfg_vals[twkm_pkg::CFG_SPACING_X] = {8'($urandom), 8'($urandom)};
          if (ph == PHASES - 1) eot_one_in = 20;
        end
      endcase

      // register writes, one per cycle
      for (k = 0; k < 4; k++) begin
        cfg_we_i <= 1'b1;
        cfg_idx_i <= twkm_pkg::cfg_idx_e'(k);
        cfg_wdata_i <= cfg_vals[k];
        @(posedge clk_i);
      end
      cfg_we_i <= 1'b0;
      scale_r = cfg_vals[twkm_pkg::CFG_SCALE];
      pad_l_r = cfg_vals[twkm_pkg::CFG_PAD_LEFT][7:0];
      pad_r_r = cfg_vals[twkm_pkg::CFG_PAD_RIGHT][7:0];
      spacing_r = cfg_vals[twkm_pkg::CFG_SPACING_X][7:0];

      // small alphabet per phase so kerning pairs actually match
      for (k = 0; k < 8; k++) alpha[k] = 8'($urandom);
      if ($urandom_range(0, 1) == 0) alpha[0] = 8'h00;

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        for (b = 0; b < burst && counted < PHASE_ITEMS; b++) begin
          sel = $urandom_range(0, 99);
          r.code = ($urandom_range(0, 9) != 0) ? alpha[$urandom_range(0, 7)] : 8'($urandom);
          case ($urandom_range(0, 5))
            0: r.lead = 8'h00;
            1: r.lead = 8'($urandom);
            default: r.lead = alpha[$urandom_range(0, 7)];
          endcase
          r.slot = 6'($urandom);
          case ($urandom_range(0, 19))
            0: amt = amt_lo;
            1: amt = amt_hi;
            default: amt = amt_lo + int'($urandom_range(0, amt_hi - amt_lo));
          endcase
          r.amount = amt[11:0];
          r.eot = ($urandom_range(1, eot_one_in) == 1);
          if (sel < 15) r.cmd = twkm_pkg::CMD_LOAD_GLYPH;
          else if (sel < 25) r.cmd = twkm_pkg::CMD_LOAD_KERN;
          else if (sel < 28) r.cmd = CMD_RESERVED;
          else r.cmd = twkm_pkg::CMD_MEASURE;
          issue(r, 1'b0, '0);
          if (r.cmd != CMD_RESERVED) counted++;
        end
        if (gap != 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      start_i <= 1'b0;
    end

    while (width_expect_q.size() != 0) @(posedge clk_i);
    repeat (twkm_pkg::KERN_DEPTH_DEF + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && width_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result checker: every strobe must match the oldest pending width
  always @(posedge clk_i) begin
    width_res_t want;
    bit         none;
    if (rst_ni && done_o === 1'b1) begin
      none = (width_expect_q.size() == 0);
      want = none ? '0 : width_expect_q.pop_front();
      if (none || running_width_o !== want.width || is_last_o !== want.last
          || glyph_missing_o !== want.missing) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t mismatch%s: width exp %0d got %0d, last exp %b got %b, %s %b got %b",
                   $realtime, none ? " (no request pending)" : "", want.width,
                   running_width_o, want.last, is_last_o, "missing exp", want.missing,
                   glyph_missing_o);
        end
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== text_width_kerning_measure.f =====
hw/rtl/twkm_pkg.sv
hw/rtl/twkm_ram.sv
hw/rtl/twkm_accum.sv
hw/rtl/text_width_kerning_measure.sv
bench/text_width_kerning_measure_tb.sv
